FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with asynchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// prop must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

FILE: design/qlps_pkg.sv
// ----------------------------------------------------------------------------
// qlps_pkg
// Types, constants and helpers of the leg phase switcher.
// ----------------------------------------------------------------------------
`default_nettype none

package qlps_pkg;

	localparam int NUM_LEGS      = 4;
	localparam int ELAPSED_BITS  = 24;
	localparam int TICKS_BITS    = 24;
	localparam int MAX_EVENTS    = 16;
	localparam int CNT_BITS      = $clog2(MAX_EVENTS + 1);

	// fixed event slots: unloading lifts, three per forced lift, timeouts
	localparam int SLOT_UNLOAD   = 0;
	localparam int SLOT_FORCED   = NUM_LEGS;
	localparam int SLOT_TIMEOUT  = SLOT_FORCED + 3 * NUM_LEGS;
	localparam int NUM_SLOTS     = SLOT_TIMEOUT + NUM_LEGS;
	localparam int SLOT_BITS     = $clog2(NUM_SLOTS);

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;

	localparam logic [CFG_IDX_BITS-1:0] CFG_UNLOAD_THRESHOLD     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SWING_MAX_TICKS      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FORE_REACH_LIMIT     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HIND_REACH_LIMIT     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FORE_LIFT_DROPS_HIND = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HIND_LIFT_DROPS_FORE = 3'd5;

	localparam logic [TICKS_BITS-1:0] TICKS_MAX = '1;

	typedef enum logic [2:0] {
		CAUSE_NEG_LOAD  = 3'd0,
		CAUSE_OVERREACH = 3'd1,
		CAUSE_CONTRA    = 3'd2,
		CAUSE_COUPLING  = 3'd3,
		CAUSE_UNLOAD    = 3'd4,
		CAUSE_TIMEOUT   = 3'd5
	} cause_t;

	typedef struct packed {
		logic signed [15:0] load_fl;
		logic signed [15:0] load_fr;
		logic signed [15:0] load_hl;
		logic signed [15:0] load_hr;
		logic [15:0]        reach_fl;
		logic [15:0]        reach_fr;
		logic [15:0]        reach_hl;
		logic [15:0]        reach_hr;
	} in_t;

	typedef struct packed {
		logic [1:0]            leg;
		logic                  lifted;
		logic [TICKS_BITS-1:0] phase_ticks;
		logic [2:0]            cause;
		logic                  last;
	} out_t;

	typedef out_t [NUM_SLOTS-1:0] slot_vec_t;

	typedef struct packed {
		logic signed [15:0] unload_threshold;
		logic [23:0]        swing_max_ticks;
		logic [15:0]        fore_reach_limit;
		logic [15:0]        hind_reach_limit;
		logic               fore_lift_drops_hind;
		logic               hind_lift_drops_fore;
	} cfg_t;

	typedef struct packed {
		logic [NUM_LEGS-1:0]                   lifted;
		logic [NUM_LEGS-1:0][15:0]             prev_load;
		logic [NUM_LEGS-1:0][ELAPSED_BITS-1:0] elapsed;
	} state_t;

	// elapsed count clipped to the event field
	function automatic logic [TICKS_BITS-1:0] sat_ticks(input logic [ELAPSED_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'(TICKS_MAX)) ? TICKS_MAX : w[TICKS_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: design/quadruped_leg_phase_switcher_unit.sv
// ----------------------------------------------------------------------------
// quadruped_leg_phase_switcher_unit
// Per-tick stance/swing switching of four legs, events serialized out.
// ----------------------------------------------------------------------------
// A tick beat is taken into an input register; the rule passes then run in one
// step against the leg state and, once the event buffer has drained, the switches
// of that tick land in a 20-slot event buffer, which drains one switch event
// beat per cycle, unless sw_ready stalls it, through the output register.
// The input side takes one tick per cycle as long as the buffer empties in
// time; a tick that causes N switch events (0 to 16) sends them one by one
// through the single event output port. The final event of a tick carries
// last. Registers are written through cfg_we/cfg_index/cfg_wdata; the user
// must do so only while no tick is in flight, which the block does not enforce.
`default_nettype none

module quadruped_leg_phase_switcher_unit (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    tick_valid,
	output logic                                   tick_ready,
	input  wire  qlps_pkg::in_t                    tick,
	output logic                                   sw_valid,
	input  wire                                    sw_ready,
	output qlps_pkg::out_t                         sw,
	input  wire                                    cfg_we,
	input  wire  [qlps_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire  [qlps_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

	qlps_pkg::cfg_t                 cfg_q;
	qlps_pkg::state_t               st_q;
	qlps_pkg::state_t               st_nxt;
	qlps_pkg::in_t                  tick_s1;
	logic                           valid_s1;
	logic                           buf_ready;
	logic                           adv;
	logic [qlps_pkg::NUM_SLOTS-1:0] mask;
	qlps_pkg::slot_vec_t            slots;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unload_threshold     <= 16'sd2458;
			cfg_q.swing_max_ticks      <= 24'd1000;
			cfg_q.fore_reach_limit     <= 16'd16794;
			cfg_q.hind_reach_limit     <= 16'd18473;
			cfg_q.fore_lift_drops_hind <= 1'b0;
			cfg_q.hind_lift_drops_fore <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				qlps_pkg::CFG_UNLOAD_THRESHOLD:     cfg_q.unload_threshold <= cfg_wdata[15:0];
				qlps_pkg::CFG_SWING_MAX_TICKS:      cfg_q.swing_max_ticks  <= cfg_wdata[23:0];
				qlps_pkg::CFG_FORE_REACH_LIMIT:     cfg_q.fore_reach_limit <= cfg_wdata[15:0];
				qlps_pkg::CFG_HIND_REACH_LIMIT:     cfg_q.hind_reach_limit <= cfg_wdata[15:0];
				qlps_pkg::CFG_FORE_LIFT_DROPS_HIND: cfg_q.fore_lift_drops_hind <= cfg_wdata[0];
				qlps_pkg::CFG_HIND_LIFT_DROPS_FORE: cfg_q.hind_lift_drops_fore <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// input stage advances once the event buffer can take the whole tick
	assign adv        = valid_s1 && buf_ready;
	assign tick_ready = !valid_s1 || buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready)
			tick_s1 <= tick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.lifted    <= 4'b0001;
			st_q.prev_load <= '0;
			st_q.elapsed   <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	qlps_eval u_eval (
		.tick   (tick_s1),
		.st     (st_q),
		.cfg    (cfg_q),
		.mask   (mask),
		.slots  (slots),
		.st_nxt (st_nxt)
	);

	qlps_evq u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.mask_i    (mask),
		.slots_i   (slots),
		.buf_ready (buf_ready),
		.sw_valid  (sw_valid),
		.sw_ready  (sw_ready),
		.sw        (sw)
	);

endmodule

`default_nettype wire

FILE: design/qlps_eval.sv
// ----------------------------------------------------------------------------
// qlps_eval
// Rule passes of one tick: event slots, slot mask and next leg state.
// ----------------------------------------------------------------------------
`default_nettype none

module qlps_eval (
	input  wire  qlps_pkg::in_t      tick,
	input  wire  qlps_pkg::state_t   st,
	input  wire  qlps_pkg::cfg_t     cfg,
	output logic [qlps_pkg::NUM_SLOTS-1:0] mask,
	output qlps_pkg::slot_vec_t      slots,
	output qlps_pkg::state_t         st_nxt
);

	logic signed [15:0] ld    [qlps_pkg::NUM_LEGS];
	logic [15:0]        reach [qlps_pkg::NUM_LEGS];

	logic [qlps_pkg::NUM_LEGS-1:0]                             lift;
	logic [qlps_pkg::NUM_LEGS-1:0][qlps_pkg::ELAPSED_BITS-1:0] el;
	logic [qlps_pkg::NUM_SLOTS-1:0]                            raw;
	logic [15:0]                                               lim;
	logic [1:0]                                                lg;
	logic [1:0]                                                cl;
	logic [1:0]                                                pl;
	logic                                                      couple;
	logic [qlps_pkg::CNT_BITS-1:0]                             cnt;

	assign ld[0]    = tick.load_fl;
	assign ld[1]    = tick.load_fr;
	assign ld[2]    = tick.load_hl;
	assign ld[3]    = tick.load_hr;
	assign reach[0] = tick.reach_fl;
	assign reach[1] = tick.reach_fr;
	assign reach[2] = tick.reach_hl;
	assign reach[3] = tick.reach_hr;

	always_comb begin
		lift   = st.lifted;
		el     = st.elapsed;
		raw    = '0;
		slots  = '0;
		lim    = '0;
		lg     = '0;
		cl     = '0;
		pl     = '0;
		couple = 1'b0;

		// unloading lifts, blocked by a lifted neighbor
		for (int k = 0; k < qlps_pkg::NUM_LEGS; k++) begin
			lg = 2'(k);
			if (!lift[lg] && ($signed(st.prev_load[lg]) > ld[k]) &&
			    (ld[k] < $signed(cfg.unload_threshold)) &&
			    !lift[lg ^ 2'd1] && !lift[lg ^ 2'd2]) begin
				raw[qlps_pkg::SLOT_UNLOAD + k]               = 1'b1;
				slots[qlps_pkg::SLOT_UNLOAD + k].leg         = lg;
				slots[qlps_pkg::SLOT_UNLOAD + k].lifted      = 1'b1;
				slots[qlps_pkg::SLOT_UNLOAD + k].phase_ticks = qlps_pkg::sat_ticks(el[lg]);
				slots[qlps_pkg::SLOT_UNLOAD + k].cause       = qlps_pkg::CAUSE_UNLOAD;
				lift[lg] = 1'b1;
				el[lg]   = '0;
			end
		end

		// forced lifts and the set-downs they pull along
		for (int k = 0; k < qlps_pkg::NUM_LEGS; k++) begin
			lg     = 2'(k);
			cl     = lg ^ 2'd1;
			pl     = lg ^ 2'd2;
			lim    = lg[1] ? cfg.hind_reach_limit : cfg.fore_reach_limit;
			couple = lg[1] ? cfg.hind_lift_drops_fore : cfg.fore_lift_drops_hind;
			if (!lift[lg] && (ld[k] < 16'sd0 || reach[k] > lim)) begin
				raw[qlps_pkg::SLOT_FORCED + 3*k]               = 1'b1;
				slots[qlps_pkg::SLOT_FORCED + 3*k].leg         = lg;
				slots[qlps_pkg::SLOT_FORCED + 3*k].lifted      = 1'b1;
				slots[qlps_pkg::SLOT_FORCED + 3*k].phase_ticks = qlps_pkg::sat_ticks(el[lg]);
				slots[qlps_pkg::SLOT_FORCED + 3*k].cause       = (ld[k] < 16'sd0) ?
					qlps_pkg::CAUSE_NEG_LOAD : qlps_pkg::CAUSE_OVERREACH;
				lift[lg] = 1'b1;
				el[lg]   = '0;
				if (lift[cl]) begin
					raw[qlps_pkg::SLOT_FORCED + 3*k + 1]               = 1'b1;
					slots[qlps_pkg::SLOT_FORCED + 3*k + 1].leg         = cl;
					slots[qlps_pkg::SLOT_FORCED + 3*k + 1].lifted      = 1'b0;
					slots[qlps_pkg::SLOT_FORCED + 3*k + 1].phase_ticks =
						qlps_pkg::sat_ticks(el[cl]);
					slots[qlps_pkg::SLOT_FORCED + 3*k + 1].cause       = qlps_pkg::CAUSE_CONTRA;
					lift[cl] = 1'b0;
					el[cl]   = '0;
				end
				if (couple && lift[pl]) begin
					raw[qlps_pkg::SLOT_FORCED + 3*k + 2]               = 1'b1;
					slots[qlps_pkg::SLOT_FORCED + 3*k + 2].leg         = pl;
					slots[qlps_pkg::SLOT_FORCED + 3*k + 2].lifted      = 1'b0;
					slots[qlps_pkg::SLOT_FORCED + 3*k + 2].phase_ticks =
						qlps_pkg::sat_ticks(el[pl]);
					slots[qlps_pkg::SLOT_FORCED + 3*k + 2].cause       =
						qlps_pkg::CAUSE_COUPLING;
					lift[pl] = 1'b0;
					el[pl]   = '0;
				end
			end
		end

		// swing timeouts
		for (int k = 0; k < qlps_pkg::NUM_LEGS; k++) begin
			lg = 2'(k);
			if (lift[lg] && (32'(el[lg]) >= 32'(cfg.swing_max_ticks))) begin
				raw[qlps_pkg::SLOT_TIMEOUT + k]               = 1'b1;
				slots[qlps_pkg::SLOT_TIMEOUT + k].leg         = lg;
				slots[qlps_pkg::SLOT_TIMEOUT + k].lifted      = 1'b0;
				slots[qlps_pkg::SLOT_TIMEOUT + k].phase_ticks = qlps_pkg::sat_ticks(el[lg]);
				slots[qlps_pkg::SLOT_TIMEOUT + k].cause       = qlps_pkg::CAUSE_TIMEOUT;
				lift[lg] = 1'b0;
				el[lg]   = '0;
			end
		end
	end

	// only the first MAX_EVENTS switches of a tick are reported
	always_comb begin
		mask = '0;
		cnt  = '0;
		for (int s = 0; s < qlps_pkg::NUM_SLOTS; s++) begin
			if (raw[s] && (32'(cnt) < 32'(qlps_pkg::MAX_EVENTS))) begin
				mask[s] = 1'b1;
				cnt     = cnt + (qlps_pkg::CNT_BITS)'(1);
			end
		end
	end

	always_comb begin
		st_nxt.lifted = lift;
		for (int k = 0; k < qlps_pkg::NUM_LEGS; k++) begin
			st_nxt.prev_load[k] = ld[k];
			st_nxt.elapsed[k]   = (el[k] == '1) ? el[k] :
				el[k] + (qlps_pkg::ELAPSED_BITS)'(1);
		end
	end

endmodule

`default_nettype wire

FILE: design/qlps_evq.sv
// ----------------------------------------------------------------------------
// qlps_evq
// Event slot buffer of one tick, drained in slot order into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qlps_evq (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  load,
	input  wire  [qlps_pkg::NUM_SLOTS-1:0]       mask_i,
	input  wire  qlps_pkg::slot_vec_t            slots_i,
	output logic                                 buf_ready,
	output logic                                 sw_valid,
	input  wire                                  sw_ready,
	output qlps_pkg::out_t                       sw
);

	logic [qlps_pkg::NUM_SLOTS-1:0] mask_q;
	qlps_pkg::slot_vec_t            slots_q;
	logic                           out_valid_q;
	qlps_pkg::out_t                 out_q;

	logic [qlps_pkg::SLOT_BITS-1:0] sel;
	logic [qlps_pkg::NUM_SLOTS-1:0] mask_rest;
	logic [qlps_pkg::NUM_SLOTS-1:0] mask_after;
	logic                           pop;
	logic                           last_sel;

	// lowest pending slot goes next
	always_comb begin
		sel = '0;
		for (int s = qlps_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
			if (mask_q[s])
				sel = (qlps_pkg::SLOT_BITS)'(s);
		end
	end

	always_comb begin
		mask_rest      = mask_q;
		mask_rest[sel] = 1'b0;
	end

	assign pop        = (|mask_q) && (!out_valid_q || sw_ready);
	assign last_sel   = (mask_rest == '0);
	assign mask_after = pop ? mask_rest : mask_q;
	assign buf_ready  = (mask_after == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else begin
			mask_q <= load ? mask_i : mask_after;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			slots_q <= slots_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (sw_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q      <= slots_q[sel];
			out_q.last <= last_sel;
		end
	end

	assign sw_valid = out_valid_q;
	assign sw       = out_q;

	`ASSERT_AT(a_load_when_drained, clk, arst_n, load |-> (mask_after == '0))
	`ASSERT_AT(a_slot_cap, clk, arst_n, $countones(mask_q) <= qlps_pkg::MAX_EVENTS)
	`ASSERT_AT(a_last_empties, clk, arst_n, (pop && last_sel && !load) |=> (mask_q == '0))
	`ASSERT_NEVER(a_pop_stall, clk, arst_n, pop && out_valid_q && !sw_ready)

endmodule

`default_nettype wire
